// ===== hw/rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsm_pkg: shared definitions for the LIFO stack with search and maximum
// Operation and status codes, field widths and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lsm_pkg;

    // Default stack depth and data width.
    localparam int LSM_DEPTH   = 64;
    localparam int LSM_DATA_W  = 32;
    localparam int LSM_COUNT_W = 7;

    // Output stream widths.
    localparam int LSM_OUT_TDATA_W = 48;
    localparam int LSM_OUT_TUSER_W = 3;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } lsm_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } lsm_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted item
        logic exec;        // apply push, pop or clear to the stack
        logic scan_issue;  // read the next stored entry
        logic out_load;    // move the result into the output register
    } lsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // a read has been issued for every stored entry
    } lsm_stat_t;

endpackage

// ===== hw/rtl/lsm_ram.sv =====
// ----------------------------------------------------------------------------
// lsm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lsm_dp.sv =====
// ----------------------------------------------------------------------------
// lsm_dp: datapath of the LIFO stack
// Holds the entry count, the stack memory, the scan accumulators for the
// maximum and the match count, and the output payload register.
// ----------------------------------------------------------------------------
module lsm_dp #(
    parameter int DEPTH = lsm_pkg::LSM_DEPTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lsm_pkg::lsm_cmd_t                      cmd,
    output lsm_pkg::lsm_stat_t                     stat,
    input  lsm_pkg::lsm_op_t                       in_op,
    input  logic signed [lsm_pkg::LSM_DATA_W-1:0]  in_value,
    output logic [lsm_pkg::LSM_COUNT_W-1:0]        depth_now,
    output logic [lsm_pkg::LSM_COUNT_W-1:0]        match_count,
    output logic signed [lsm_pkg::LSM_DATA_W-1:0]  largest_value,
    output logic                                   is_empty,
    output lsm_pkg::lsm_status_t                   status_code
);

    import lsm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    lsm_op_t                      op_reg;
    logic signed [LSM_DATA_W-1:0] value_reg;
    lsm_status_t                  status_reg, status_next;
    logic [CW-1:0]                top_reg, top_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic signed [LSM_DATA_W-1:0] max_reg, max_next;
    logic                         rd_pending_reg;
    logic                         rd_first_reg;
    logic                         ram_we;
    logic signed [LSM_DATA_W-1:0] ram_rdata;
    logic [CW+LSM_COUNT_W-1:0]    depth_ext;
    logic [CW+LSM_COUNT_W-1:0]    cnt_ext;

    // Stack memory: pushes write at the top, the scan reads upward from entry 0.
    lsm_ram #(
        .WIDTH (LSM_DATA_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (top_reg[AW-1:0]),
        .wdata (value_reg),
        .re    (cmd.scan_issue),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Captured item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
    end

    // Stack update for the captured operation.
    always_comb
    begin
        top_next    = top_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            case (op_reg)
                OP_PUSH:
                begin
                    if (top_reg == FULL_COUNT)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        top_next = top_reg + CW'(1);
                    end
                end
                OP_POP:
                begin
                    if (top_reg == '0)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        top_next = top_reg - CW'(1);
                    end
                end
                OP_CLEAR:
                begin
                    top_next = '0;
                end
                default:
                begin
                    top_next = top_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // Scan accumulators: running maximum and match count of the stored entries.
    always_comb
    begin
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        max_next = max_reg;
        if (cmd.exec)
        begin
            idx_next = '0;
            cnt_next = '0;
            max_next = '0;
        end
        else
        begin
            if (cmd.scan_issue)
            begin
                idx_next = idx_reg + CW'(1);
            end
            if (rd_pending_reg)
            begin
                if (rd_first_reg || (ram_rdata > max_reg))
                begin
                    max_next = ram_rdata;
                end
                if ((op_reg == OP_FIND) && (ram_rdata == value_reg))
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        max_reg <= max_next;
    end

    // Read data is registered and arrives in the cycle after the address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pending_reg <= 1'b0;
            rd_first_reg   <= 1'b0;
        end
        else
        begin
            rd_pending_reg <= cmd.scan_issue;
            rd_first_reg   <= cmd.scan_issue && (idx_reg == '0);
        end
    end

    assign stat.scan_done = (idx_reg == top_reg);

    // Counts are reported in the low bits of the field.
    assign depth_ext = {{LSM_COUNT_W{1'b0}}, top_reg};
    assign cnt_ext   = {{LSM_COUNT_W{1'b0}}, cnt_reg};

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            depth_now     <= depth_ext[LSM_COUNT_W-1:0];
            match_count   <= cnt_ext[LSM_COUNT_W-1:0];
            largest_value <= max_reg;
            is_empty      <= (top_reg == '0);
            status_code   <= status_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= FULL_COUNT)
        else $error("entry count exceeds the stack depth");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (op_reg == OP_PUSH) && (top_reg == FULL_COUNT))
        |=> ((top_reg == FULL_COUNT) && (status_reg == STAT_FULL)))
        else $error("push onto a full stack changed the stack");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (idx_reg < top_reg))
        else $error("scan read beyond the stored entries");
`endif

endmodule

// ===== hw/rtl/lsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsm_ctrl: controller of the LIFO stack
// Sequences accept, stack update, entry scan and result hand-off, and owns
// the input ready and output valid flags.
// ----------------------------------------------------------------------------
module lsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output lsm_pkg::lsm_cmd_t  cmd,
    input  lsm_pkg::lsm_stat_t stat
);

    import lsm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        cmd.scan_issue = 1'b0;
        cmd.out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start the stack update");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("output valid raised outside the hand-off state");
`endif

endmodule

// ===== hw/rtl/lifo_stack_with_search_max.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_max: bounded LIFO stack with find and maximum
// Push, pop, find and clear on a stack of signed 32-bit values; every item
// yields one result with depth, match count, maximum and status.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_ channel: s_tuser carries the operation (push, pop,
// find, clear) and s_tdata the value. One result per item leaves on the m_
// channel. The block takes one item at a time. After the stack update the
// controller reads every stored entry once through the memory's read port to
// form the maximum and the match count. Each item passes through the update,
// scan, drain and hand-off states in that order before its result is valid.
// The next item is taken in the cycle after the result is loaded into the
// output register, even while that result still waits to be taken. If the
// receiver stalls, the finished result is held and the next item stops at the
// hand-off until the register is free. Reset empties the stack at once and
// clears the output valid flag; the memory itself is not cleared, since only
// entries that were pushed are ever read.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_max #(
    parameter int DEPTH = lsm_pkg::LSM_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lsm_pkg::LSM_DATA_W-1:0]       s_tdata,   // item_value[31:0]
    input  logic [1:0]                           s_tuser,   // cmd[1:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // depth_now[6:0], match_count[13:7], largest_value[45:14], zero fill [47:46]
    output logic [lsm_pkg::LSM_OUT_TDATA_W-1:0]  m_tdata,
    // is_empty[0], status_code[2:1]
    output logic [lsm_pkg::LSM_OUT_TUSER_W-1:0]  m_tuser
);

    import lsm_pkg::*;

    lsm_cmd_t                     cmd;
    lsm_stat_t                    stat;
    logic [LSM_COUNT_W-1:0]       depth_now;
    logic [LSM_COUNT_W-1:0]       match_count;
    logic signed [LSM_DATA_W-1:0] largest_value;
    logic                         is_empty;
    lsm_status_t                  status_code;

    // Controller.
    lsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Datapath.
    lsm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (lsm_op_t'(s_tuser)),
        .in_value      (s_tdata),
        .depth_now     (depth_now),
        .match_count   (match_count),
        .largest_value (largest_value),
        .is_empty      (is_empty),
        .status_code   (status_code)
    );

    // Pack the result fields.
    assign m_tdata = {2'b00, largest_value, match_count, depth_now};
    assign m_tuser = {status_code, is_empty};

endmodule

// ===== tb/tb_lifo_stack_with_search_max.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search_max: self-checking bench for the bounded stack
// A short directed run covers the empty and extreme cases. Random segments
// then fill, drain, mix and repeat values so that the stack reaches both full
// and empty. A shadow stack in the bench predicts every result, and each
// output item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search_max;

    import lsm_pkg::*;

    localparam int STACK_DEPTH = LSM_DEPTH;
    localparam int ITEM_TARGET = 1250;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = STACK_DEPTH + 16;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 30;
    localparam int MAX_REPORTS = 10;

    // One command toward the block.
    typedef struct packed {
        lsm_op_t            op;
        logic signed [31:0] value;
    } stack_item_t;

    // One result from the block, unpacked.
    typedef struct packed {
        logic [6:0]         depth_now;
        logic [6:0]         match_count;
        logic signed [31:0] largest_value;
        logic               is_empty;
        lsm_status_t        status;
    } stack_result_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [LSM_DATA_W-1:0]       s_tdata  = '0;
    logic [1:0]                  s_tuser  = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [LSM_OUT_TDATA_W-1:0]  m_tdata;
    logic [LSM_OUT_TUSER_W-1:0]  m_tuser;

    stack_item_t                 pending_items[$];
    stack_result_t               expected_results[$];

    // Shadow of the stack contents.
    logic signed [31:0]          shadow_store [STACK_DEPTH];
    int                          shadow_depth = 0;

    logic signed [31:0]          value_pool [8];
    logic                        item_taken = 1'b0;
    int                          results_seen = 0;
    int                          error_count = 0;
    int                          idle_cycles = 0;

    always #1 clk = ~clk;

    lifo_stack_with_search_max #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Apply one command to the shadow stack and work out its result.
    function automatic stack_result_t apply_stack_op(lsm_op_t op, logic signed [31:0] value);
        stack_result_t res;
        int            hits;
        res.status = STAT_OK;
        hits = 0;
        case (op)
            OP_PUSH:
            begin
                if (shadow_depth >= STACK_DEPTH)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    shadow_store[shadow_depth] = value;
                    shadow_depth++;
                end
            end
            OP_POP:
            begin
                if (shadow_depth == 0)
                    res.status = STAT_EMPTY;
                else
                    shadow_depth--;
            end
            OP_FIND:
            begin
                for (int i = 0; i < shadow_depth; i++)
                begin
                    if (shadow_store[i] == value)
                        hits++;
                end
            end
            default:
            begin
                shadow_depth = 0;
            end
        endcase
        res.depth_now     = shadow_depth[6:0];
        res.match_count   = hits[6:0];
        res.largest_value = '0;
        if (shadow_depth > 0)
        begin
            res.largest_value = shadow_store[0];
            for (int i = 1; i < shadow_depth; i++)
            begin
                if (shadow_store[i] > res.largest_value)
                    res.largest_value = shadow_store[i];
            end
        end
        res.is_empty = (shadow_depth == 0);
        return res;
    endfunction

    // Count a failure; only the first few are printed in full.
    task automatic note_mismatch(string what, longint want_v, longint got_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 99) < 55)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic add_item(lsm_op_t op, logic signed [31:0] value);
        stack_item_t it;
        it.op    = op;
        it.value = value;
        pending_items.push_back(it);
    endtask

    // Sender: offers items in bursts, with random gaps between bursts.
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        stack_item_t it;
        if (rst_n)
        begin
            if (!s_tvalid || item_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.value;
                    s_tuser  <= it.op;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode now and then, plus one long hold-off.
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  ready_mode = 0;
    int  mode_left  = 0;
    int  phase      = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            phase++;
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(40, 300);
                end
                else
                begin
                    mode_left--;
                end
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (phase % 5 != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Monitor: predict on each accepted item, check each accepted result.
    always @(posedge clk)
    begin
        stack_result_t want;
        stack_result_t got;
        if (rst_n)
        begin
            item_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_stack_op(lsm_op_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.depth_now     = m_tdata[6:0];
                got.match_count   = m_tdata[13:7];
                got.largest_value = m_tdata[45:14];
                got.is_empty      = m_tuser[0];
                got.status        = lsm_status_t'(m_tuser[2:1]);
                if (expected_results.size() == 0)
                begin
                    note_mismatch("result with nothing expected, depth_now", -1, got.depth_now);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.depth_now != want.depth_now)
                        note_mismatch("depth_now", want.depth_now, got.depth_now);
                    if (got.match_count != want.match_count)
                        note_mismatch("match_count", want.match_count, got.match_count);
                    if (got.largest_value != want.largest_value)
                        note_mismatch("largest_value", want.largest_value, got.largest_value);
                    if (got.is_empty != want.is_empty)
                        note_mismatch("is_empty", want.is_empty, got.is_empty);
                    if (got.status != want.status)
                        note_mismatch("status_code", want.status, got.status);
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int          seg_kind;
        int          seg_len;
        int          roll;
        logic signed [31:0] seg_value;

        value_pool[0] = 32'sd0;
        value_pool[1] = 32'sd1;
        value_pool[2] = -32'sd1;
        value_pool[3] = 32'h8000_0000;
        value_pool[4] = 32'h7FFF_FFFF;
        value_pool[5] = 32'h5555_5555;
        value_pool[6] = 32'hAAAA_AAAA;
        value_pool[7] = 32'sd42;

        // Directed: empty-stack cases, extremes, counting and clearing.
        add_item(OP_POP, 32'sd7);
        add_item(OP_FIND, 32'sd0);
        add_item(OP_CLEAR, 32'hFFFF_FFFF);
        add_item(OP_PUSH, 32'h8000_0000);
        add_item(OP_PUSH, 32'h7FFF_FFFF);
        add_item(OP_PUSH, -32'sd1);
        add_item(OP_PUSH, 32'sd0);
        add_item(OP_PUSH, -32'sd1);
        add_item(OP_FIND, -32'sd1);
        add_item(OP_FIND, 32'h8000_0000);
        add_item(OP_FIND, 32'sd5);
        add_item(OP_POP, 32'sd0);
        add_item(OP_POP, 32'h7FFF_FFFF);
        add_item(OP_FIND, -32'sd1);
        add_item(OP_CLEAR, 32'sd0);
        add_item(OP_PUSH, -32'sd2);
        add_item(OP_PUSH, 32'h8000_0000);
        add_item(OP_POP, 32'sd0);
        add_item(OP_POP, 32'sd0);
        add_item(OP_POP, 32'sd0);
        add_item(OP_PUSH, 32'h5555_5555);
        add_item(OP_FIND, 32'h5555_5555);
        add_item(OP_CLEAR, 32'sd0);

        // Random segments: fill, drain, mixed, and one repeated value.
        while (pending_items.size() < ITEM_TARGET)
        begin
            seg_kind  = $urandom_range(0, 3);
            seg_len   = $urandom_range(20, 120);
            seg_value = pick_value();
            for (int n = 0; n < seg_len; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    add_item(OP_CLEAR, $urandom);
                else if (seg_kind == 0)
                    add_item(roll < 80 ? OP_PUSH : (roll < 90 ? OP_FIND : OP_POP), pick_value());
                else if (seg_kind == 1)
                    add_item(roll < 75 ? OP_POP : (roll < 88 ? OP_FIND : OP_PUSH), pick_value());
                else if (seg_kind == 2)
                    add_item(lsm_op_t'($urandom_range(0, 2)), pick_value());
                else
                    add_item(roll < 85 ? OP_PUSH : OP_FIND, seg_value);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
